/* hw/rtl/acp_pkg.sv */
// ----------------------------------------------------------------------------
// acp_pkg
// Shared types and constants of the adaptive conflict predictor: operation
// and register codes, the command passed from front to back, the table entry.
// ----------------------------------------------------------------------------
package acp_pkg;

  // default geometry
  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int PREFIX_BYTES_DEF  = 4;
  localparam int QUEUE_DEPTH       = 2;

  // key byte count, wide enough for any prefix length up to eight
  localparam int KCNT_W = 4;

  // operation codes on the op port
  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_RECORD = 2'd1;
  localparam logic [1:0] OP_DECAY  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_SAMPLES  = 2'd0;
  localparam logic [1:0] CFG_RATE_DIVISOR = 2'd1;
  localparam logic [1:0] CFG_DECAY_WINDOW = 2'd2;

  // reset values of the configuration registers
  localparam logic [15:0] MIN_SAMPLES_RST  = 16'd10;
  localparam logic [9:0]  RATE_DIVISOR_RST = 10'd100;
  localparam logic [63:0] DECAY_WINDOW_RST = 64'd60000000000;

  // work kind decided by the front
  typedef enum logic [1:0] {
    CMD_NOP    = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_RECORD = 2'd2,
    CMD_DECAY  = 2'd3
  } cmd_kind_t;

  // command handed to the back; stamp is the time to store on record
  // or the age threshold on decay
  typedef struct packed {
    cmd_kind_t   kind;
    logic        conflict_seen;
    logic [63:0] stamp;
  } cmd_t;

  // one table entry
  typedef struct packed {
    logic [63:0] last_time;
    logic [31:0] conflicts;
    logic [31:0] accesses;
  } entry_t;

endpackage

/* hw/rtl/acp_ram.sv */
// ----------------------------------------------------------------------------
// acp_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module acp_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/acp_queue.sv */
// ----------------------------------------------------------------------------
// acp_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module acp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = acp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/acp_front.sv */
// ----------------------------------------------------------------------------
// acp_front
// Accepts a transaction, classifies it, hashes the key prefix one byte per
// cycle, reduces the hash to a table index and pushes a command.
// ----------------------------------------------------------------------------
module acp_front #(
  parameter int TABLE_ENTRIES = acp_pkg::TABLE_ENTRIES_DEF,
  parameter int PREFIX_BYTES  = acp_pkg::PREFIX_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [1:0]                       op,
  input  logic                             has_key,
  input  logic [2:0]                       key_length,
  input  logic [31:0]                      key_prefix,
  input  logic                             conflict_seen,
  input  logic [63:0]                      now_time,
  input  logic [63:0]                      decay_window,
  output logic                             busy,
  output logic                             push,
  output acp_pkg::cmd_t                    push_cmd,
  output logic [$clog2(TABLE_ENTRIES)-1:0] push_idx,
  input  logic                             full
);

  localparam int IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int HASH_BASE = 8 + 5 * PREFIX_BYTES;
  localparam int HASH_W    = (HASH_BASE > IDX_W) ? HASH_BASE : IDX_W;
  localparam int REM_W     = IDX_W + 1;
  localparam int MCNT_W    = $clog2(HASH_W + 1);
  localparam bit IS_POW2   = (TABLE_ENTRIES == (1 << IDX_W));

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_HASH = 4'b0010,
    F_MOD  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  front_state_t                    state;
  acp_pkg::cmd_t                   cmd;
  logic [HASH_W-1:0]               hash;
  logic [31:0]                     bytes;
  logic [acp_pkg::KCNT_W-1:0]      kcnt;
  logic [REM_W-1:0]                rem;
  logic [MCNT_W-1:0]               mcnt;

  logic [acp_pkg::KCNT_W-1:0]      klen;
  logic [acp_pkg::KCNT_W-1:0]      nbytes;
  acp_pkg::cmd_kind_t              kind;
  logic [HASH_W-1:0]               hash_step;
  logic [REM_W-1:0]                rem_shift;
  logic [REM_W-1:0]                rem_next;

  // number of bytes to hash, capped at the prefix length
  assign klen   = {1'b0, key_length};
  assign nbytes = (klen > acp_pkg::KCNT_W'(PREFIX_BYTES)) ?
                  acp_pkg::KCNT_W'(PREFIX_BYTES) : klen;

  // classify the incoming transaction
  always_comb begin
    case (op)
      acp_pkg::OP_QUERY:  kind = has_key ? acp_pkg::CMD_QUERY : acp_pkg::CMD_NOP;
      acp_pkg::OP_RECORD: kind = has_key ? acp_pkg::CMD_RECORD : acp_pkg::CMD_NOP;
      acp_pkg::OP_DECAY:  kind = acp_pkg::CMD_DECAY;
      default:            kind = acp_pkg::CMD_NOP;
    endcase
  end

  // h * 31 + next byte
  assign hash_step = (hash << 5) - hash + HASH_W'(bytes[7:0]);

  // restoring remainder, one hash bit per cycle
  assign rem_shift = {rem[IDX_W-1:0], hash[HASH_W-1]};
  assign rem_next  = (rem_shift >= REM_W'(TABLE_ENTRIES)) ?
                     rem_shift - REM_W'(TABLE_ENTRIES) : rem_shift;

  assign busy     = (state != F_IDLE);
  assign push     = (state == F_PUSH) && !full;
  assign push_cmd = cmd;
  assign push_idx = IS_POW2 ? hash[IDX_W-1:0] : rem[IDX_W-1:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            cmd.kind          <= kind;
            cmd.conflict_seen <= conflict_seen;
            cmd.stamp         <= (kind == acp_pkg::CMD_DECAY) ?
                                 now_time - decay_window : now_time;
            hash  <= '0;
            bytes <= key_prefix;
            kcnt  <= nbytes;
            rem   <= '0;
            mcnt  <= MCNT_W'(HASH_W);
            if (kind == acp_pkg::CMD_QUERY || kind == acp_pkg::CMD_RECORD) begin
              if (nbytes != '0) begin
                state <= F_HASH;
              end else begin
                state <= IS_POW2 ? F_PUSH : F_MOD;
              end
            end else begin
              state <= F_PUSH;
            end
          end
        end
        F_HASH: begin
          hash  <= hash_step;
          bytes <= bytes >> 8;
          kcnt  <= kcnt - 1'b1;
          if (kcnt == acp_pkg::KCNT_W'(1)) begin
            state <= IS_POW2 ? F_PUSH : F_MOD;
          end
        end
        F_MOD: begin
          rem  <= rem_next;
          hash <= hash << 1;
          mcnt <= mcnt - 1'b1;
          if (mcnt == MCNT_W'(1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/acp_back.sv */
// ----------------------------------------------------------------------------
// acp_back
// Owns the counter table: clears it after reset, runs a query as a read and a
// record as a read-modify-write and walks the whole table for a decay sweep.
// ----------------------------------------------------------------------------
module acp_back #(
  parameter int TABLE_ENTRIES = acp_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             empty,
  output logic                             pop,
  input  acp_pkg::cmd_t                    pop_cmd,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] pop_idx,
  input  logic [15:0]                      min_samples,
  input  logic [9:0]                       rate_divisor,
  output logic                             clearing,
  output logic                             done,
  output logic                             check_needed
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int ENT_W = $bits(acp_pkg::entry_t);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [6:0] {
    B_CLEAR     = 7'b0000001,
    B_IDLE      = 7'b0000010,
    B_READ      = 7'b0000100,
    B_DATA      = 7'b0001000,
    B_QCMP      = 7'b0010000,
    B_SWEEP     = 7'b0100000,
    B_SWEEP_END = 7'b1000000
  } back_state_t;

  back_state_t      state;
  acp_pkg::cmd_t    cmd;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] wa;
  logic             sv;
  logic [31:0]      acc_q;
  logic [41:0]      prod;
  logic             below;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  acp_pkg::entry_t  wr_entry;
  logic [ENT_W-1:0] rd_raw;
  acp_pkg::entry_t  rd_entry;
  acp_pkg::entry_t  rec_entry;
  acp_pkg::entry_t  dec_entry;

  acp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_entry = acp_pkg::entry_t'(rd_raw);

  // updated entry for a record
  always_comb begin
    rec_entry.accesses  = rd_entry.accesses + 32'd1;
    rec_entry.conflicts = rd_entry.conflicts + {31'd0, cmd.conflict_seen};
    rec_entry.last_time = cmd.stamp;
  end

  // halved entry for a decay sweep when older than the threshold
  always_comb begin
    dec_entry = rd_entry;
    if (rd_entry.last_time < cmd.stamp) begin
      dec_entry.accesses  = rd_entry.accesses >> 1;
      dec_entry.conflicts = rd_entry.conflicts >> 1;
    end
  end

  // table port control
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = idx;
    wr_en    = 1'b0;
    wr_addr  = ptr;
    wr_entry = '0;
    case (state)
      B_CLEAR: begin
        wr_en = 1'b1;
      end
      B_READ: begin
        rd_en = 1'b1;
      end
      B_DATA: begin
        if (cmd.kind == acp_pkg::CMD_RECORD) begin
          wr_en    = 1'b1;
          wr_addr  = idx;
          wr_entry = rec_entry;
        end
      end
      B_SWEEP: begin
        rd_en    = 1'b1;
        rd_addr  = ptr;
        wr_en    = sv;
        wr_addr  = wa;
        wr_entry = dec_entry;
      end
      B_SWEEP_END: begin
        wr_en    = 1'b1;
        wr_addr  = wa;
        wr_entry = dec_entry;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign pop      = (state == B_IDLE) && !empty;
  assign clearing = (state == B_CLEAR);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      ptr   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        B_CLEAR: begin
          if (ptr == LAST) begin
            ptr   <= '0;
            state <= B_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        B_IDLE: begin
          if (!empty) begin
            cmd <= pop_cmd;
            idx <= pop_idx;
            case (pop_cmd.kind)
              acp_pkg::CMD_NOP: begin
                done         <= 1'b1;
                check_needed <= 1'b0;
              end
              acp_pkg::CMD_DECAY: begin
                ptr   <= '0;
                sv    <= 1'b0;
                state <= B_SWEEP;
              end
              default: state <= B_READ;
            endcase
          end
        end
        B_READ: begin
          state <= B_DATA;
        end
        B_DATA: begin
          if (cmd.kind == acp_pkg::CMD_QUERY) begin
            prod  <= 42'(rd_entry.conflicts) * 42'(rate_divisor);
            acc_q <= rd_entry.accesses;
            below <= rd_entry.accesses < {16'd0, min_samples};
            state <= B_QCMP;
          end else begin
            done         <= 1'b1;
            check_needed <= 1'b0;
            state        <= B_IDLE;
          end
        end
        B_QCMP: begin
          done         <= 1'b1;
          check_needed <= below || (prod > {10'd0, acc_q});
          state        <= B_IDLE;
        end
        B_SWEEP: begin
          sv <= 1'b1;
          wa <= ptr;
          if (ptr == LAST) begin
            state <= B_SWEEP_END;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        B_SWEEP_END: begin
          done         <= 1'b1;
          check_needed <= 1'b0;
          state        <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/adaptive_conflict_predictor.sv */
// ----------------------------------------------------------------------------
// adaptive_conflict_predictor
// Predicts whether a conflict check is worth doing from per-pattern counts.
//
// Command channel: a transaction is taken when start is high and busy low.
// Each transaction gives one result: done is high for exactly one cycle with
// check_needed; the receiver cannot stall, so results are never held back.
// Config channel: cfg_valid with cfg_index and cfg_data, cfg_ready always
// high; write only while the block is idle.
// A non power-of-two table adds a bitwise restoring remainder for the index
// reduction over the hash, whose width is the wider of 8 + 5 * PREFIX_BYTES
// and the index width; a power-of-two table takes the low hash bits.
// The front can take the next transaction while the back still works on the
// previous one; the two-entry queue between them absorbs it.
// Reset: config registers return to their defaults and the table is
// cleared by a pass over all TABLE_ENTRIES entries, during which busy stays high.
// ----------------------------------------------------------------------------
module adaptive_conflict_predictor #(
  parameter int TABLE_ENTRIES = acp_pkg::TABLE_ENTRIES_DEF,
  parameter int PREFIX_BYTES  = acp_pkg::PREFIX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic        has_key,
  input  logic [2:0]  key_length,
  input  logic [31:0] key_prefix,
  input  logic        conflict_seen,
  input  logic [63:0] now_time,
  output logic        done,
  output logic        check_needed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CMD_W = $bits(acp_pkg::cmd_t);
  localparam int Q_W   = CMD_W + IDX_W;

  logic [15:0]      min_samples;
  logic [9:0]       rate_divisor;
  logic [63:0]      decay_window;

  logic             accept;
  logic             front_busy;
  logic             clearing;
  logic             push;
  acp_pkg::cmd_t    push_cmd;
  logic [IDX_W-1:0] push_idx;
  logic             full;
  logic             pop;
  logic [Q_W-1:0]   pop_data;
  logic             empty;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples  <= acp_pkg::MIN_SAMPLES_RST;
      rate_divisor <= acp_pkg::RATE_DIVISOR_RST;
      decay_window <= acp_pkg::DECAY_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        acp_pkg::CFG_MIN_SAMPLES:  min_samples  <= cfg_data[15:0];
        acp_pkg::CFG_RATE_DIVISOR: rate_divisor <= cfg_data[9:0];
        acp_pkg::CFG_DECAY_WINDOW: decay_window <= cfg_data;
        default:                   min_samples  <= min_samples;
      endcase
    end
  end

  // command acceptance
  assign busy   = front_busy || clearing;
  assign accept = start && !busy;

  acp_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PREFIX_BYTES  (PREFIX_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .op            (op),
    .has_key       (has_key),
    .key_length    (key_length),
    .key_prefix    (key_prefix),
    .conflict_seen (conflict_seen),
    .now_time      (now_time),
    .decay_window  (decay_window),
    .busy          (front_busy),
    .push          (push),
    .push_cmd      (push_cmd),
    .push_idx      (push_idx),
    .full          (full)
  );

  acp_queue #(
    .WIDTH (Q_W),
    .DEPTH (acp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_cmd, push_idx}),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  acp_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop          (pop),
    .pop_cmd      (acp_pkg::cmd_t'(pop_data[Q_W-1:IDX_W])),
    .pop_idx      (pop_data[IDX_W-1:0]),
    .min_samples  (min_samples),
    .rate_divisor (rate_divisor),
    .clearing     (clearing),
    .done         (done),
    .check_needed (check_needed)
  );

endmodule
